FILE: rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, types and the exponential table for the softmax unit.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MaxLenDefault = 64;
  localparam int ValueWidth    = 16;
  localparam int ExpWidth      = 17;
  localparam int SumWidth      = 23;
  localparam logic [15:0] Log2eQ15 = 16'd47274;

  // 2^(-j/16) in Q1.16, j = 0..16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] r;
    case (j)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      5'd16:   r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // sequencer states
  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_ERD   = 7'b0000010,
    ST_EXP1  = 7'b0000100,
    ST_EXP2  = 7'b0001000,
    ST_DRD   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  // divider control
  typedef struct packed {
    logic        go;
    logic [16:0] num;
    logic [SumWidth-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/core/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write one entry when enabled; always read the addressed entry
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div
// Restoring divider: (num*65536 + den/2) / den, saturated to 16 bits.
// One quotient bit per cycle across the 34-bit dividend.
// ----------------------------------------------------------------------------
module smx_div import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [15:0] quot
);
  localparam int NW = 17 + 16 + 1;
  localparam int QW = NW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]       dividend;
  logic [SumWidth:0]   rem;
  logic [QW-1:0]       q;
  logic [SumWidth-1:0] den;
  logic [CW-1:0]       cnt;
  logic                run;
  logic [SumWidth:0]   trial;
  logic [SumWidth+1:0] sub;

  always_comb begin
    trial = {rem[SumWidth-1:0], dividend[NW-1]};
    sub   = {1'b0, trial} - {2'b0, den};
  end

  // shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run      <= 1'b1;
        den      <= req.den;
        dividend <= {1'b0, req.num, 16'd0} + {12'd0, req.den[SumWidth-1:1]};
        rem      <= '0;
        q        <= '0;
        cnt      <= CW'(NW);
      end else if (run) begin
        dividend <= {dividend[NW-2:0], 1'b0};
        if (!sub[SumWidth+1]) begin
          rem <= sub[SumWidth:0];
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate; zero sum gives zero
  assign quot = (den == '0) ? 16'd0 : ((q[QW-1:16] != '0) ? 16'hFFFF : q[15:0]);
endmodule

FILE: rtl/core/softmax_vector_unit.sv
// ----------------------------------------------------------------------------
// softmax_vector_unit
// Fixed-point softmax over a vector streamed one element per transfer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// input     in         start & !busy    value, last
// result    out        strobe (1 cycle) probability, last_res, overflowed
//
// A non-last element is accepted and stored while the unit stays in load. On
// last, an exponential pass visits each stored element in turn (RAM read,
// exponential multiply, interpolate and write back), then a division pass
// runs each element through the bit-serial divider and emits its result.
// busy stays high until the last result is out.
// Reset (synchronous) clears count, maximum, sum and flag; no RAM clearing.
// The receiver cannot stall; each result stands for one cycle.
module softmax_vector_unit import smx_pkg::*; #(
  parameter int MAX_LEN = MaxLenDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [ValueWidth-1:0] value,
  input  logic                         last,
  output logic                         busy,
  output logic                         strobe,
  output logic [15:0]                  probability,
  output logic                         last_res,
  output logic                         overflowed
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  state_t state;
  logic [CW-1:0] count, idx;
  logic signed [ValueWidth-1:0] run_max;
  logic [SumWidth-1:0] exp_sum;
  logic ovf;

  logic we;
  logic [AW-1:0] addr;
  logic [ExpWidth-1:0] wdata, rdata;

  logic accept;
  assign accept = start && (state == ST_LOAD);
  assign busy   = (state != ST_LOAD);

  smx_ram #(.Width(ExpWidth), .Depth(MAX_LEN)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // exponential stage 1: d * log2(e)
  logic signed [ValueWidth:0] diff;
  logic [15:0] d;
  logic [31:0] y_r;
  assign diff = run_max - $signed(rdata[ValueWidth-1:0]);
  assign d    = diff[ValueWidth] ? 16'd0 : diff[15:0];

  // exponential stage 2: table interpolate and shift
  logic [16:0] yq;
  logic [4:0]  n;
  logic [3:0]  k;
  logic [7:0]  r;
  logic [16:0] hi, lo, m;
  logic [24:0] prod;
  logic [16:0] e;
  always_comb begin
    yq   = y_r[31:15];
    n    = yq[16:12];
    k    = yq[11:8];
    r    = yq[7:0];
    hi   = pow2_tab({1'b0, k});
    lo   = pow2_tab({1'b0, k} + 5'd1);
    prod = (hi - lo) * r + 25'd128;
    m    = hi - 17'(prod[24:8]);
    if (n == 5'd0) e = m;
    else           e = 17'(({1'b0, m} + (18'd1 << (n - 5'd1))) >> n);
  end

  div_req_t dreq;
  logic div_go;
  logic ddone;
  logic [15:0] dq;
  smx_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));

  // RAM port steering; launch the divide once the read data has landed
  always_comb begin
    we    = 1'b0;
    addr  = idx[AW-1:0];
    wdata = '0;
    if (accept) begin
      addr  = count[AW-1:0];
      wdata = {1'b0, value};
      we    = (count < CW'(MAX_LEN));
    end else if (state == ST_EXP2) begin
      we    = 1'b1;
      wdata = e;
    end
    dreq.go  = div_go;
    dreq.num = rdata;
    dreq.den = exp_sum;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      idx     <= '0;
      run_max <= 16'sh8000;
      exp_sum <= '0;
      ovf     <= 1'b0;
      strobe  <= 1'b0;
      div_go  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (count < CW'(MAX_LEN)) begin
              count <= count + 1'b1;
              if (value > run_max) run_max <= value;
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              idx   <= '0;
              state <= ST_ERD;
            end
          end
        end
        ST_ERD:  state <= ST_EXP1;
        ST_EXP1: begin
          y_r   <= d * Log2eQ15 + 32'd16384;
          state <= ST_EXP2;
        end
        ST_EXP2: begin
          exp_sum <= exp_sum + SumWidth'(e);
          if (idx + 1'b1 == count) begin
            idx   <= '0;
            state <= ST_DRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_ERD;
          end
        end
        ST_DRD: begin
          div_go <= 1'b1;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (ddone) state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe      <= 1'b1;
          probability <= dq;
          last_res    <= (idx + 1'b1 == count);
          overflowed  <= ovf;
          if (idx + 1'b1 == count) begin
            count   <= '0;
            run_max <= 16'sh8000;
            exp_sum <= '0;
            ovf     <= 1'b0;
            state   <= ST_LOAD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_DRD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

FILE: tb/softmax_vector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_vector_unit_tb
// Streams vectors into the softmax unit with random gaps, predicts every
// probability with a fixed-point model of its own, and compares each strobed
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module softmax_vector_unit_tb import smx_pkg::*; ();

  localparam int Cap = MaxLenDefault;

  typedef struct {
    logic [15:0] prob;
    logic        lst;
    logic        ovf;
  } prob_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic signed [ValueWidth-1:0] value;
  logic                         last;
  logic                         busy;
  logic                         strobe;
  logic [15:0]                  probability;
  logic                         last_res;
  logic                         overflowed;

  // predictor state
  logic signed [15:0] held_vals[$];
  logic signed [15:0] peak;
  bit                 dropped;
  prob_t              pending_probs[$];
  int                 errors = 0;
  bit                 allow_gaps = 1;

  softmax_vector_unit uut (
    .clk(clk), .rst(rst), .start(start), .value(value), .last(last),
    .busy(busy), .strobe(strobe), .probability(probability),
    .last_res(last_res), .overflowed(overflowed)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // exp(-d) in Q1.16 by table plus linear interpolation
  function automatic longint exp_neg(input longint d);
    longint y, n, f, k, r, hi, lo, m;
    y  = (d * 47274 + 16384) >> 15;
    n  = y >> 12;
    f  = y & 4095;
    k  = f >> 8;
    r  = f & 255;
    hi = pow2_tab(k[4:0]);
    lo = pow2_tab(k[4:0] + 5'd1);
    m  = hi - (((hi - lo) * r + 128) >> 8);
    if (n == 0) return m;
    if (n >= 24) return 0;
    return (m + (longint'(1) << (n - 1))) >> n;
  endfunction

  // fold one accepted element into the run; on last, queue its probabilities
  task automatic predict_softmax(input logic signed [15:0] v, input logic l);
    longint exps[$];
    longint total, p, d;
    prob_t  res;
    if (held_vals.size() < Cap) begin
      held_vals.push_back(v);
      if (v > peak) peak = v;
    end else begin
      dropped = 1;
    end
    if (l) begin
      total = 0;
      foreach (held_vals[i]) begin
        d = longint'(peak) - longint'(held_vals[i]);
        if (d < 0) d = 0;
        exps.push_back(exp_neg(d));
        total = (total + exps[i]) & 'h7FFFFF;
      end
      foreach (exps[i]) begin
        p = 0;
        if (total != 0) begin
          p = (exps[i] * 65536 + (total >> 1)) / total;
          if (p > 65535) p = 65535;
        end
        res.prob = p[15:0];
        res.lst  = (i == exps.size() - 1);
        res.ovf  = dropped;
        pending_probs.push_back(res);
      end
      held_vals.delete();
      peak    = -16'sd32768;
      dropped = 0;
    end
  endtask

  // transfer one element, with an optional idle gap before it
  task automatic send_elem(input logic signed [15:0] v, input logic l);
    int gap;
    if (allow_gaps && $urandom_range(99) < 34) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    value = v;
    last  = l;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_softmax(v, l);
  endtask

  task automatic send_vector(input int len, input int spread);
    logic signed [15:0] v;
    int base;
    base = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      if (spread == 0) v = 16'($urandom);
      else v = 16'(base + $urandom_range(2 * spread) - spread);
      send_elem(v, i == len - 1);
    end
  endtask

  // check each strobed result against the oldest prediction
  always @(posedge clk) begin
    prob_t exp_r;
    if (!rst && strobe) begin
      if (pending_probs.size() == 0) begin
        $display("%0t: unexpected result probability=%0d", $time, probability);
        errors++;
      end else begin
        exp_r = pending_probs.pop_front();
        if (probability !== exp_r.prob) begin
          $display("%0t: probability expected %0d actual %0d",
                   $time, exp_r.prob, probability);
          errors++;
        end
        if (last_res !== exp_r.lst) begin
          $display("%0t: last_res expected %0b actual %0b", $time, exp_r.lst, last_res);
          errors++;
        end
        if (overflowed !== exp_r.ovf) begin
          $display("%0t: overflowed expected %0b actual %0b",
                   $time, exp_r.ovf, overflowed);
          errors++;
        end
      end
    end
  end

  task automatic test_single_elements();
    send_elem(16'sh7FFF, 1'b1);
    send_elem(-16'sd32768, 1'b1);
    send_elem(16'sd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_elem(-16'sd32768, 1'b0);
    send_elem(16'sh7FFF, 1'b1);
    send_elem(16'sd4096, 1'b0);
    send_elem(16'sd4096, 1'b0);
    send_elem(16'sd4096, 1'b1);
    send_elem(16'sd0, 1'b0);
    send_elem(-16'sd4096, 1'b0);
    send_elem(-16'sd8192, 1'b0);
    send_elem(16'sh5555, 1'b0);
    send_elem(-16'sh5556, 1'b1);
  endtask

  // fill the store back to back, then drop two more including the last
  task automatic test_overflow();
    allow_gaps = 0;
    for (int i = 0; i < Cap; i++) send_elem(16'($urandom_range(8191) - 4096), 1'b0);
    allow_gaps = 1;
    send_elem(16'sh7FFF, 1'b0);
    send_elem(16'sh7FFF, 1'b1);
  endtask

  task automatic test_random_runs();
    int sent;
    sent = 0;
    while (sent < 30) begin
      int len;
      int spread;
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      case ($urandom_range(2))
        0: spread = 0;
        1: spread = 8192;
        default: spread = 1024;
      endcase
      send_vector(len, spread);
      sent += len;
    end
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    value   = '0;
    last    = 1'b0;
    peak    = -16'sd32768;
    dropped = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_single_elements();
    test_extremes();
    test_overflow();
    test_random_runs();
    @(negedge clk);
    start = 1'b0;
    // drain outstanding results, then allow the tail to settle
    while (pending_probs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // hard stop on a hang
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
